[rtl/spq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the sorted priority queue cell row
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;
  localparam int CAP_RESET = 16;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/spq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted row: compares against the broadcast value and
// takes the new value, its upper neighbor or its lower neighbor
// ----------------------------------------------------------------------------
module spq_cell (
  input  wire                      clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire spq_pkg::word_t      value,
  input  wire                      slot_valid,
  input  wire                      prev_take,
  input  wire spq_pkg::word_t      prev_data,
  input  wire spq_pkg::word_t      next_data,
  output logic                     take,
  output spq_pkg::word_t           data
);

  // slot sits at or behind the insert point
  assign take = !slot_valid || ($signed(value) >= $signed(data));

  always_ff @(posedge clk) begin
    if (ctrl.enq && take) begin
      data <= prev_take ? prev_data : value;
    end else if (ctrl.deq) begin
      data <= next_data;
    end
  end

endmodule
`default_nettype wire

[rtl/sorted_priority_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// descending sorted store held in a row of shifting cells, head at cell 0
// ----------------------------------------------------------------------------
// result: an accepted transaction is held in op_r and value_r, then executed
//   into the output registers once the output register is free
// a new transaction is accepted only after the previous one has updated
//   the cell row; a held result delays the update
// reset: count cleared, capacity set to 16, no result pending;
//   cell contents are not cleared
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [31:0]  s_tdata,   // value[31:0]
  input  wire  [0:0]   s_tuser,   // operation[0]
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [103:0] m_tdata,   // removed_value[31:0], head_value[63:32],
                                  // tail_value[95:64], entry_count[100:96], zero
  output logic [1:0]   m_tuser,   // status[1:0]
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [4:0]   cfg_data   // capacity[4:0]
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (IDX_W + 1 > spq_pkg::COUNT_W) ? IDX_W + 1 : spq_pkg::COUNT_W;

  logic                          busy;
  spq_pkg::op_t                  op_r;
  spq_pkg::word_t                value_r;
  logic [spq_pkg::COUNT_W-1:0]   occupancy;
  logic [spq_pkg::COUNT_W-1:0]   occupancy_next;
  logic [spq_pkg::COUNT_W-1:0]   capacity;
  logic [spq_pkg::COUNT_W-1:0]   cap_limit;
  spq_pkg::word_t                tail;
  spq_pkg::word_t                tail_next;
  spq_pkg::word_t                head_next;
  spq_pkg::word_t                removed_next;
  spq_pkg::status_t              status_next;
  spq_pkg::status_t              status_r;
  spq_pkg::word_t                removed_r;
  spq_pkg::word_t                head_r;
  spq_pkg::word_t                tail_r;
  logic [spq_pkg::COUNT_W-1:0]   count_r;
  logic                          out_free;
  logic                          exec;
  logic                          full;
  logic                          enq_ok;
  logic                          deq_ok;
  spq_pkg::cell_ctrl_t           ctrl;

  spq_pkg::word_t                cell_data  [DEPTH];
  logic                          cell_take  [DEPTH];
  logic                          cell_valid [DEPTH];

  assign s_tready  = !busy;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign exec      = busy && out_free;

  always_comb begin
    if (32'(capacity) > DEPTH) begin
      cap_limit = spq_pkg::COUNT_W'(DEPTH);
    end else begin
      cap_limit = capacity;
    end
  end

  assign full   = occupancy >= cap_limit;
  assign enq_ok = exec && (op_r == spq_pkg::OP_ENQ) && !full;
  assign deq_ok = exec && (op_r == spq_pkg::OP_DEQ) && (occupancy != '0);
  assign ctrl   = '{enq: enq_ok, deq: deq_ok};

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic           prev_take;
      spq_pkg::word_t prev_data;
      spq_pkg::word_t next_data;

      assign cell_valid[gi] = CMP_W'(occupancy) > CMP_W'(gi);

      if (gi == 0) begin : g_first
        assign prev_take = 1'b0;
        assign prev_data = value_r;
      end else begin : g_mid
        assign prev_take = cell_take[gi-1];
        assign prev_data = cell_data[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign next_data = cell_data[gi];
      end else begin : g_inner
        assign next_data = cell_data[gi+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .value      (value_r),
        .slot_valid (cell_valid[gi]),
        .prev_take  (prev_take),
        .prev_data  (prev_data),
        .next_data  (next_data),
        .take       (cell_take[gi]),
        .data       (cell_data[gi])
      );
    end
  endgenerate

  always_comb begin
    status_next    = spq_pkg::ST_DONE;
    removed_next   = '0;
    occupancy_next = occupancy;
    tail_next      = tail;
    head_next      = cell_data[0];
    case (op_r)
      spq_pkg::OP_ENQ: begin
        if (full) begin
          status_next = spq_pkg::ST_FULL;
        end else begin
          occupancy_next = occupancy + 1'b1;
          head_next      = cell_take[0] ? value_r : cell_data[0];
          if ((occupancy == '0) || ($signed(value_r) < $signed(tail))) begin
            tail_next = value_r;
          end
        end
      end
      spq_pkg::OP_DEQ: begin
        if (occupancy == '0) begin
          status_next = spq_pkg::ST_EMPTY;
        end else begin
          removed_next   = cell_data[0];
          occupancy_next = occupancy - 1'b1;
          head_next      = cell_data[(DEPTH > 1) ? 1 : 0];
        end
      end
      default: begin
        status_next = spq_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      occupancy <= '0;
      capacity  <= spq_pkg::COUNT_W'(spq_pkg::CAP_RESET);
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (s_tvalid && s_tready) begin
        busy <= 1'b1;
      end else if (exec) begin
        busy <= 1'b0;
      end
      if (exec) begin
        occupancy <= occupancy_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r    <= spq_pkg::op_t'(s_tuser[0]);
      value_r <= s_tdata;
    end
    if (exec) begin
      tail      <= tail_next;
      status_r  <= status_next;
      removed_r <= removed_next;
      head_r    <= (occupancy_next == '0) ? '0 : head_next;
      tail_r    <= (occupancy_next == '0) ? '0 : tail_next;
      count_r   <= occupancy_next;
    end
  end

  assign m_tuser = status_r;
  assign m_tdata = {3'b000, count_r, tail_r, head_r, removed_r};

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(occupancy) <= CMP_W'(DEPTH))
    else $error("occupancy above depth");

  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    enq_ok |=> occupancy == $past(occupancy) + 1'b1)
    else $error("enqueue did not grow count");

  a_deq_head: assert property (@(posedge clk) disable iff (rst)
    deq_ok |=> removed_r == $past(cell_data[0]))
    else $error("dequeue lost head entry");

  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    (busy && !out_free) |=> busy)
    else $error("transaction dropped while output stalled");

endmodule
`default_nettype wire
